@@ design/rtts_pkg.sv @@
// Shared types and constants for the RGBA raster to 4x4 tile swizzle.
// Pixel and result payloads, the position struct and the per-pixel tile request.
// No dependencies.
`default_nettype none

package rtts_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int TILE        = 4;
  localparam int STORED_ROWS = 3;
  localparam int MAX_TILES   = MAX_WIDTH / TILE;
  localparam int MAX_BANDS   = 1024;
  localparam int WORDS       = 2 * TILE;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW_W   = $clog2(MAX_WIDTH + 1);
  localparam int BAND_W = $clog2(MAX_BANDS);
  localparam int HB_W   = 11;
  localparam int WT_W   = 9;
  localparam int CFG_W  = 11;
  localparam int CNT_W  = $clog2(WORDS);

  localparam logic [1:0] LAST_ROW = 2'(STORED_ROWS);
  localparam logic [1:0] TILE_END = 2'(TILE - 1);

  typedef enum logic [0:0] {
    REG_WIDTH_TILES  = 1'b0,
    REG_HEIGHT_BANDS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic        tile_last;
    logic        frame_last;
  } result_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [1:0]       row;
    logic             frame_end;
  } pos_t;

  typedef struct packed {
    logic       valid;
    logic       done;
    logic [1:0] k;
    logic       frame_end;
    pixel_t     px;
  } tile_req_t;

endpackage

`default_nettype wire

@@ design/rgba_raster_to_4x4_tile_swizzle_top.sv @@
// Top level of the RGBA raster to 4x4 tile swizzle.
// Instantiates rtts_pos_ctrl, rtts_line_mem and rtts_tile_buf; uses rtts_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in      | input     | in_valid/in_stall  | pixel_t: red, green, blue, alpha
//   out     | output    | out_valid/out_stall| result_t: data_word, tile_last, frame_last
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Rows 0-2 of a band take one pixel per cycle while in_stall is low, written
// into the line store. Fourth-row pixels read the line store at acceptance and
// meet that data in the next cycle; a tile-closing pixel then loads the word
// buffer, which drains eight words at one per cycle while out_stall is low.
// The first word follows the stage and tile registers; the buffer paces row four.
// Reset clears counters and control; line store contents stay undefined.
// out_stall holds the current word; in_stall rises only while a tile-closing
// pixel waits for the word buffer to hand out the last word of the previous tile.
`default_nettype none

module rgba_raster_to_4x4_tile_swizzle_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rtts_pkg::pixel_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rtts_pkg::result_t          out_data,
  input  logic                       cfg_we,
  input  rtts_pkg::cfg_reg_t         cfg_index,
  input  logic [rtts_pkg::CFG_W-1:0] cfg_data
);
  import rtts_pkg::*;

  logic                     accept;
  logic                     block;
  pos_t                     pos;
  tile_req_t                req;
  logic                     mem_we;
  logic                     mem_re;
  logic [STORED_ROWS-1:0]   lane_en;
  pixel_t [STORED_ROWS-1:0] rdata;

  assign in_stall = block;
  assign accept   = in_valid && !block;

  always_comb begin
    mem_we  = accept && (pos.row != LAST_ROW);
    mem_re  = accept && (pos.row == LAST_ROW);
    lane_en = STORED_ROWS'(1) << pos.row;

    req.valid     = mem_re;
    req.done      = (pos.col[1:0] == TILE_END);
    req.k         = pos.col[1:0];
    req.frame_end = pos.frame_end;
    req.px        = in_data;
  end

  rtts_pos_ctrl u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .pos       (pos)
  );

  rtts_line_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .lane_en (lane_en),
    .addr    (pos.col),
    .wdata   (in_data),
    .re      (mem_re),
    .rdata   (rdata)
  );

  rtts_tile_buf u_tile (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rdata     (rdata),
    .block     (block),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ design/rtts_line_mem.sv @@
// Line store for the first three rows of a band: one entry per column,
// three pixel lanes per entry, lane write enables, registered read.
// Depends on rtts_pkg.
`default_nettype none

module rtts_line_mem (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [rtts_pkg::STORED_ROWS-1:0]       lane_en,
  input  logic [rtts_pkg::COL_W-1:0]             addr,
  input  rtts_pkg::pixel_t                       wdata,
  input  logic                                   re,
  output rtts_pkg::pixel_t [rtts_pkg::STORED_ROWS-1:0] rdata
);
  import rtts_pkg::*;

  pixel_t [STORED_ROWS-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    for (int i = 0; i < STORED_ROWS; i++) begin
      if (we && lane_en[i]) begin
        mem[addr][i] <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ design/rtts_pos_ctrl.sv @@
// Configuration registers and frame position counters (column, row in band, band).
// Clamps the register values to their valid ranges when used and flags row and frame ends.
// Depends on rtts_pkg.
`default_nettype none

module rtts_pos_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  rtts_pkg::cfg_reg_t         cfg_index,
  input  logic [rtts_pkg::CFG_W-1:0] cfg_data,
  input  logic                       advance,
  output rtts_pkg::pos_t             pos
);
  import rtts_pkg::*;

  logic [WT_W-1:0]   width_tiles;
  logic [HB_W-1:0]   height_bands;
  logic [COL_W-1:0]  col;
  logic [1:0]        row;
  logic [BAND_W-1:0] band;

  logic [31:0]       tiles_sat;
  logic [EW_W-1:0]   width_eff;
  logic [EW_W-1:0]   col_inc;
  logic [HB_W-1:0]   height_eff;
  logic [HB_W-1:0]   band_inc;
  logic              row_end;
  logic              last_band;

  always_comb begin
    if (width_tiles == '0) begin
      tiles_sat = 32'd1;
    end else if (32'(width_tiles) > 32'(MAX_TILES)) begin
      tiles_sat = 32'(MAX_TILES);
    end else begin
      tiles_sat = 32'(width_tiles);
    end
    width_eff = EW_W'(tiles_sat << 2);
    col_inc   = EW_W'(col) + EW_W'(1);
    row_end   = (col_inc >= width_eff);

    if (height_bands == '0) begin
      height_eff = HB_W'(1);
    end else if (height_bands > HB_W'(MAX_BANDS)) begin
      height_eff = HB_W'(MAX_BANDS);
    end else begin
      height_eff = height_bands;
    end
    band_inc  = HB_W'(band) + HB_W'(1);
    last_band = (band_inc >= height_eff);
  end

  assign pos.col       = col;
  assign pos.row       = row;
  assign pos.frame_end = row_end && last_band;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_tiles  <= WT_W'(160);
      height_bands <= HB_W'(132);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH_TILES:  width_tiles  <= cfg_data[WT_W-1:0];
        REG_HEIGHT_BANDS: height_bands <= cfg_data[HB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      band <= '0;
    end else if (advance) begin
      if (row_end) begin
        col <= '0;
        if (row == LAST_ROW) begin
          row  <= '0;
          band <= last_band ? '0 : band_inc[BAND_W-1:0];
        end else begin
          row <= row + 2'd1;
        end
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/rtts_tile_buf.sv @@
// Tile assembly and word emitter: gathers fourth-row columns with line store
// data, loads a completed 4x4 tile and streams its eight words.
// Depends on rtts_pkg.
`default_nettype none

module rtts_tile_buf (
  input  logic                                         clk,
  input  logic                                         rst,
  input  rtts_pkg::tile_req_t                          req,
  input  rtts_pkg::pixel_t [rtts_pkg::STORED_ROWS-1:0] rdata,
  output logic                                         block,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output rtts_pkg::result_t                            out_data
);
  import rtts_pkg::*;

  logic             s1_valid;
  logic             s1_done;
  logic [1:0]       s1_k;
  logic             s1_frame_end;
  pixel_t           s1_px;

  pixel_t [TILE-1:0]           colbuf [TILE-1];
  pixel_t [TILE-1:0][TILE-1:0] tile;
  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic                        tile_fe;

  logic             buf_free;
  logic             load;
  logic             out_take;
  pixel_t [TILE-1:0] cur_col;
  logic [63:0]      word;

  always_comb begin
    out_take = busy && !out_stall;
    buf_free = !busy || (cnt == CNT_W'(WORDS - 1) && !out_stall);
    block    = s1_valid && s1_done && !buf_free;
    load     = s1_valid && s1_done && buf_free;
    for (int r = 0; r < STORED_ROWS; r++) begin
      cur_col[r] = rdata[r];
    end
    cur_col[TILE-1] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!block) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!block && req.valid) begin
      s1_done      <= req.done;
      s1_k         <= req.k;
      s1_frame_end <= req.frame_end;
      s1_px        <= req.px;
    end
    if (s1_valid && !s1_done) begin
      colbuf[s1_k] <= cur_col;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int r = 0; r < TILE; r++) begin
        for (int c = 0; c < TILE - 1; c++) begin
          tile[r][c] <= colbuf[c][r];
        end
        tile[r][TILE-1] <= cur_col[r];
      end
      tile_fe <= s1_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (out_take) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    pixel_t p;
    word = '0;
    for (int c = 0; c < TILE; c++) begin
      p = tile[cnt[1:0]][c];
      if (cnt[2]) begin
        word[63 - 16*c -: 16] = {p.green, p.blue};
      end else begin
        word[63 - 16*c -: 16] = {p.alpha, p.red};
      end
    end
  end

  assign out_valid           = busy;
  assign out_data.data_word  = word;
  assign out_data.tile_last  = (cnt == CNT_W'(WORDS - 1));
  assign out_data.frame_last = (cnt == CNT_W'(WORDS - 1)) && tile_fe;

endmodule

`default_nettype wire

@@ test/rtts_tile_checker.sv @@
// Checker for the RGBA raster to 4x4 tile swizzle: watches the pixel, result and
// register ports, predicts the tile words of each pixel and compares them in order.
// Depends on rtts_pkg for the payload types and sizes.
module rtts_tile_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  rtts_pkg::pixel_t           in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  rtts_pkg::result_t          out_data,
  input  logic                       cfg_we,
  input  rtts_pkg::cfg_reg_t         cfg_index,
  input  logic [rtts_pkg::CFG_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         outstanding
);
  import rtts_pkg::*;

  localparam int RESET_WIDTH_TILES  = 160;
  localparam int RESET_HEIGHT_BANDS = 132;

  logic [WT_W-1:0] width_tiles_q;
  logic [HB_W-1:0] height_bands_q;
  pixel_t          band_rows [STORED_ROWS][MAX_WIDTH];
  pixel_t          tail_px [STORED_ROWS];
  int unsigned     col_q;
  int unsigned     row_q;
  int unsigned     band_q;
  result_t         pending_words [$];

  function automatic int unsigned width_px();
    int unsigned t;
    t = 32'(width_tiles_q);
    if (t < 1) t = 1;
    if (t > MAX_TILES) t = MAX_TILES;
    return t * TILE;
  endfunction

  function automatic int unsigned height_in_bands();
    int unsigned h;
    h = 32'(height_bands_q);
    if (h < 1) h = 1;
    if (h > MAX_BANDS) h = MAX_BANDS;
    return h;
  endfunction

  task automatic swizzle_pixel(input pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned base;
    logic        row_end;
    logic        frame_end;
    pixel_t      p;
    result_t     word;
    w = width_px();
    h = height_in_bands();
    row_end = (col_q + 1 >= w);
    if (row_q < STORED_ROWS) begin
      band_rows[row_q][col_q] = px;
    end else if (col_q % TILE != TILE - 1) begin
      tail_px[col_q % TILE] = px;
    end else begin
      base = col_q - (TILE - 1);
      frame_end = row_end && (band_q + 1 >= h);
      for (int i = 0; i < WORDS; i++) begin
        word = '0;
        for (int k = 0; k < TILE; k++) begin
          if (i % TILE < STORED_ROWS) p = band_rows[i % TILE][base + k];
          else if (k < TILE - 1) p = tail_px[k];
          else p = px;
          if (i < TILE) word.data_word[63 - 16 * k -: 16] = {p.alpha, p.red};
          else word.data_word[63 - 16 * k -: 16] = {p.green, p.blue};
        end
        word.tile_last = (i == WORDS - 1);
        word.frame_last = (i == WORDS - 1) && frame_end;
        pending_words.push_back(word);
      end
    end
    if (row_end) begin
      col_q = 0;
      if (row_q == STORED_ROWS) begin
        row_q = 0;
        band_q = (band_q + 1 >= h) ? 0 : band_q + 1;
      end else begin
        row_q++;
      end
    end else begin
      col_q++;
    end
  endtask

  task automatic check_word(input result_t got);
    result_t want;
    if (pending_words.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected word: expected none, actual data %h tile_last %b frame_last %b",
               $time, got.data_word, got.tile_last, got.frame_last);
    end else begin
      want = pending_words.pop_front();
      if (got.data_word !== want.data_word || got.tile_last !== want.tile_last ||
          got.frame_last !== want.frame_last) begin
        mismatches++;
        $display("%0t: word mismatch: expected data %h tile_last %b frame_last %b,",
                 $time, want.data_word, want.tile_last, want.frame_last,
                 " actual data %h tile_last %b frame_last %b",
                 got.data_word, got.tile_last, got.frame_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_tiles_q = WT_W'(RESET_WIDTH_TILES);
      height_bands_q = HB_W'(RESET_HEIGHT_BANDS);
      col_q = 0;
      row_q = 0;
      band_q = 0;
      mismatches = 0;
      pending_words.delete();
    end else begin
      if (out_valid && !out_stall) check_word(out_data);
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH_TILES:  width_tiles_q = cfg_data[WT_W-1:0];
          REG_HEIGHT_BANDS: height_bands_q = cfg_data[HB_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) swizzle_pixel(in_data);
    end
    outstanding <= pending_words.size();
  end

endmodule

@@ test/rgba_raster_to_4x4_tile_swizzle_top_tb.sv @@
// Testbench top for the RGBA raster to 4x4 tile swizzle: drives pixels, register
// writes and output stalls, and gives the verdict from rtts_tile_checker.
// Depends on rtts_pkg, rtts_tile_checker and rgba_raster_to_4x4_tile_swizzle_top.
module rgba_raster_to_4x4_tile_swizzle_top_tb;
  import rtts_pkg::*;

  localparam int SETTLE       = 16;
  localparam int PIXEL_TARGET = 460;
  localparam int WIDEST_TILES = 511;
  localparam int TALLEST      = 2047;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  pixel_t           in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  result_t          out_data;
  logic             cfg_we = 1'b0;
  cfg_reg_t         cfg_index = REG_WIDTH_TILES;
  logic [CFG_W-1:0] cfg_data = '0;
  int               mismatches;
  int               outstanding;
  bit               quiet = 1'b0;
  int               pixels_sent = 0;
  int               frames = 0;

  rgba_raster_to_4x4_tile_swizzle_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rtts_tile_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic push_pixel(input pixel_t px);
    int gap;
    gap = quiet ? 0 : $urandom_range(12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_tiles();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    pixel_t      px;
    int unsigned cur_w;
    int unsigned cur_h;
    int unsigned n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Widest and tallest settings, then shrink the width in the middle of row 0
    // and the height in the middle of the frame.
    write_reg(REG_WIDTH_TILES, WIDEST_TILES);
    write_reg(REG_HEIGHT_BANDS, TALLEST);
    for (int i = 0; i < 34; i++) begin
      if (i == 5) begin
        drain_tiles();
        write_reg(REG_WIDTH_TILES, 0);
      end
      if (i == 18) begin
        drain_tiles();
        write_reg(REG_HEIGHT_BANDS, 0);
      end
      case (i % 4)
        0: px = '0;
        1: px = '1;
        2: px = (i % 8 == 2) ? 32'h5AA5_C33C : 32'hA55A_3CC3;
        default: px = $urandom;
      endcase
      push_pixel(px);
    end
    drain_tiles();
    frames++;
    cur_w = 0;
    cur_h = 0;

    while (pixels_sent < PIXEL_TARGET) begin
      if ($urandom_range(3) != 0) begin
        cur_w = ($urandom_range(7) == 0) ? 0 : $urandom_range(5, 1);
        write_reg(REG_WIDTH_TILES, cur_w);
      end
      if ($urandom_range(3) != 0) begin
        cur_h = ($urandom_range(7) == 0) ? 0 : $urandom_range(3, 1);
        write_reg(REG_HEIGHT_BANDS, cur_h);
      end
      quiet = ($urandom_range(3) == 0);
      n = 16 * (cur_w == 0 ? 1 : cur_w) * (cur_h == 0 ? 1 : cur_h);
      for (int unsigned j = 0; j < n; j++) push_pixel(pixel_t'($urandom));
      drain_tiles();
      frames++;
    end

    @(negedge clk);
    $display("Sent %0d pixels in %0d frames, with saturated and mid-frame register writes,",
             pixels_sent, frames);
    $display("random pixel values and random input gaps and output stalls.");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d tile words still outstanding", outstanding);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
design/rtts_pkg.sv
design/rtts_line_mem.sv
design/rtts_pos_ctrl.sv
design/rtts_tile_buf.sv
design/rgba_raster_to_4x4_tile_swizzle_top.sv
test/rtts_tile_checker.sv
test/rgba_raster_to_4x4_tile_swizzle_top_tb.sv
